### design/frobenius_distance_macros.svh
// Assertion macros for the frobenius_distance block.
// Expect clk and rst in the scope of use.
`ifndef FROBENIUS_DISTANCE_MACROS_SVH
`define FROBENIUS_DISTANCE_MACROS_SVH

`ifndef SYNTH

`define FD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define FD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define FD_ASSERT(lbl, prop, msg)

`define FD_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### design/fd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_pkg
// Widths, types and state codes shared by the frobenius_distance modules.
// ----------------------------------------------------------------------------
package fd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ACC_WIDTH    = 48;
  localparam int NORM_WIDTH   = 24;

  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int MAG_W  = SAMPLE_WIDTH;
  localparam int SQ_W   = 2 * MAG_W;

  // square root: one result bit per iteration
  localparam int ROOT_W    = (ACC_WIDTH + 1) / 2;
  localparam int X_W       = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int CNT_W     = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;
  localparam int RES_PAD_W = ((ROOT_W > NORM_WIDTH) ? ROOT_W : NORM_WIDTH) + 1;

  localparam logic [ACC_WIDTH-1:0] ACC_TOP = '1;

  typedef struct packed {
    logic [ACC_WIDTH-1:0] sum;
    logic                 sat;
  } fd_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fd_q_stat_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_DONE
  } fd_sqrt_state_t;

endpackage

### design/fd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_in_if / fd_out_if
// Valid/ready channels for element pairs and norm results.
// ----------------------------------------------------------------------------
interface fd_in_if import fd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] elem_a;
  logic [SAMPLE_WIDTH-1:0] elem_b;
  logic                    last_element;

  modport source (output valid, elem_a, elem_b, last_element, input ready);
  modport sink   (input valid, elem_a, elem_b, last_element, output ready);
endinterface

interface fd_out_if import fd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [NORM_WIDTH-1:0] norm;
  logic                  overflow;

  modport source (output valid, norm, overflow, input ready);
  modport sink   (input valid, norm, overflow, output ready);
endinterface

### design/fd_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_accum
// Front end: difference, square and saturating sum; pushes one job per matrix.
// ----------------------------------------------------------------------------
`include "frobenius_distance_macros.svh"

module fd_accum import fd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fd_in_if.sink      samples,
  input  fd_q_stat_t q_stat,
  output logic       push,
  output fd_job_t    job
);

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;

  logic             v1;
  logic [MAG_W-1:0] mag1;
  logic             last1;

  logic             v2;
  logic [SQ_W-1:0]  sq2;
  logic             last2;

  logic [ACC_WIDTH-1:0] sum;
  logic                 sat;
  logic [ACC_WIDTH:0]   sum_ext;
  logic [ACC_WIDTH-1:0] sum_next;
  logic                 sat_next;

  logic acc_go;
  logic s2_ready;
  logic s1_ready;

  assign diff = $signed({samples.elem_a[SAMPLE_WIDTH-1], samples.elem_a})
              - $signed({samples.elem_b[SAMPLE_WIDTH-1], samples.elem_b});
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // the last pair of a matrix waits in stage 2 until the queue has room
  assign acc_go   = v2 && !(last2 && q_stat.full);
  assign s2_ready = !v2 || acc_go;
  assign s1_ready = !v1 || s2_ready;
  assign samples.ready = s1_ready;

  assign sum_ext  = {1'b0, sum} + {{(ACC_WIDTH + 1 - SQ_W){1'b0}}, sq2};
  assign sum_next = sum_ext[ACC_WIDTH] ? ACC_TOP : sum_ext[ACC_WIDTH-1:0];
  assign sat_next = sat | sum_ext[ACC_WIDTH];

  assign push    = acc_go && last2;
  assign job.sum = sum_next;
  assign job.sat = sat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= samples.valid;
    end
    if (s1_ready) begin
      mag1  <= diff_abs[MAG_W-1:0];
      last1 <= samples.last_element;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_ready) begin
      v2 <= v1;
    end
    if (s2_ready) begin
      sq2   <= mag1 * mag1;
      last2 <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      sat <= 1'b0;
    end else if (acc_go) begin
      if (last2) begin
        sum <= '0;
        sat <= 1'b0;
      end else begin
        sum <= sum_next;
        sat <= sat_next;
      end
    end
  end

  `FD_ASSERT(a_push_room, !(push && q_stat.full), "job pushed into a full queue")
  `FD_ASSERT(a_sat_top, !sat || (sum == ACC_TOP), "saturation flag without clamped sum")
  `FD_ASSERT_NEXT(a_clear_after_push, push, (sum == '0) && !sat, "sum not cleared after last pair")

endmodule

### design/fd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_queue
// Two-entry FIFO of finished sums between the accumulator and the root unit.
// ----------------------------------------------------------------------------
module fd_queue import fd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  fd_job_t    wr_job,
  input  logic       pop,
  output fd_job_t    rd_job,
  output fd_q_stat_t stat
);

  fd_job_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign rd_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

### design/fd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd_sqrt
// Back end: digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`include "frobenius_distance_macros.svh"

module fd_sqrt import fd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fd_job_t    job,
  input  fd_q_stat_t q_stat,
  output logic       pop,
  fd_out_if.source   result
);

  fd_sqrt_state_t state;
  fd_sqrt_state_t state_next;

  logic [X_W-1:0]    x;
  logic [ROOT_W-1:0] res;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              sat;

  logic [REM_W-1:0]     rem_sh;
  logic [REM_W-1:0]     trial;
  logic                 take;
  logic [RES_PAD_W-1:0] res_pad;

  assign rem_sh  = {rem[REM_W-3:0], x[X_W-1 -: 2]};
  assign trial   = {res, 2'b01};
  assign take    = (rem_sh >= trial);
  assign res_pad = RES_PAD_W'(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    result.valid = 1'b0;
    unique case (state)
      SQ_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (cnt == '0) begin
          state_next = SQ_DONE;
        end
      end
      SQ_DONE: begin
        result.valid = 1'b1;
        if (result.ready) begin
          state_next = SQ_IDLE;
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x   <= X_W'(job.sum);
      sat <= job.sat;
      res <= '0;
      rem <= '0;
      cnt <= CNT_W'(ROOT_W - 1);
    end else if (state == SQ_RUN) begin
      x   <= {x[X_W-3:0], 2'b00};
      cnt <= cnt - CNT_W'(1);
      if (take) begin
        rem <= rem_sh - trial;
        res <= {res[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        res <= {res[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // clamp when the root is wider than the norm field
  assign result.norm     = ((res_pad >> NORM_WIDTH) != '0) ? '1 : res_pad[NORM_WIDTH-1:0];
  assign result.overflow = sat;

  `FD_ASSERT_NEXT(a_pop_starts, pop, state == SQ_RUN, "root unit did not start after pop")
  `FD_ASSERT(a_rem_bound, (state != SQ_RUN) || (rem <= {res, 1'b0}), "remainder out of bound")
  `FD_ASSERT(a_pop_nonempty, !(pop && q_stat.empty), "pop from empty queue")

endmodule

### design/frobenius_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frobenius_distance
// Streaming Frobenius norm of the difference of two matrices, Q8.8 fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          transfer ends
//  samples   in   elem_a, elem_b, last_element     element pair
//  result    out  norm, overflow                   one per matrix
//
//  Element pairs are taken one per cycle while samples is not stalled; a pair
//  passes the registered magnitude and square stages before it is added to
//  the sum. The root unit works on one sum at a time, one root bit per cycle;
//  a two-entry queue holds finished sums meanwhile.
//  samples stalls only when the last pair of a matrix finds the queue full.
//  rst is synchronous; it clears the sum, the queue and the root unit.
// ----------------------------------------------------------------------------
module frobenius_distance import fd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  fd_in_if.sink    samples,
  fd_out_if.source result
);

  logic       push;
  logic       pop;
  fd_job_t    wr_job;
  fd_job_t    rd_job;
  fd_q_stat_t q_stat;

  fd_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_stat  (q_stat),
    .push    (push),
    .job     (wr_job)
  );

  fd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  fd_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .job    (rd_job),
    .q_stat (q_stat),
    .pop    (pop),
    .result (result)
  );

endmodule
